// ----- src/lmss_pkg.sv -----
// Shared constants, types and request codes of the LED matrix shadow store.
package lmss_pkg;

  // Chain size and store geometry.
  localparam int MODULES = 4;
  localparam int ROWS = 8;
  localparam int DEPTH = MODULES * ROWS;
  localparam int MIDX_W = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int ADDR_W = MIDX_W + 3;

  // Request operation codes.
  localparam logic [2:0] OP_SET_ROW = 3'd0;
  localparam logic [2:0] OP_SET_COL = 3'd1;
  localparam logic [2:0] OP_SET_LED = 3'd2;
  localparam logic [2:0] OP_GLB_COL = 3'd3;
  localparam logic [2:0] OP_GLB_LED = 3'd4;
  localparam logic [2:0] OP_REFRESH = 3'd5;

  // How a visited row is changed.
  typedef enum logic [1:0] {
    KIND_ROW,
    KIND_BIT,
    KIND_REF
  } kind_t;

  // Decoded request handed from the decoder to the sequencer.
  typedef struct packed {
    logic              ok;
    kind_t             kind;
    logic              single;
    logic [MIDX_W-1:0] mod_idx;
    logic [2:0]        row_idx;
    logic [2:0]        col_idx;
    logic [7:0]        bits;
  } req_t;

endpackage

// ----- src/lmss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/lmss_decode.sv -----
// Request decoder: range checks and mapping of a request to rows to visit.
module lmss_decode (
  input  logic          [2:0] operation,
  input  logic          [3:0] row,
  input  logic          [5:0] column,
  input  logic          [2:0] module_req,
  input  logic          [7:0] pixel_bits,
  input  logic                led_on,
  output lmss_pkg::req_t      req
);

  logic                        row_ok;
  logic                        lcol_ok;
  logic                        gcol_ok;
  logic                        mod_ok;
  logic [5:0]                  col_m1;
  logic [lmss_pkg::MIDX_W-1:0] lmod;
  logic [lmss_pkg::MIDX_W-1:0] gmod;

  // Range checks and index conversion.
  always_comb begin
    row_ok  = (row >= 4'd1) && (row <= 4'(lmss_pkg::ROWS));
    lcol_ok = (column >= 6'd1) && (column <= 6'd8);
    gcol_ok = (column >= 6'd1) && ({1'b0, column} <= 7'(8 * lmss_pkg::MODULES));
    mod_ok  = (module_req >= 3'd1) && ({1'b0, module_req} <= 4'(lmss_pkg::MODULES));
    col_m1  = column - 6'd1;
    lmod    = lmss_pkg::MIDX_W'(module_req - 3'd1);
    gmod    = lmss_pkg::MIDX_W'(col_m1[5:3]);
  end

  // Operation decode.
  always_comb begin
    req.ok      = 1'b0;
    req.kind    = lmss_pkg::KIND_ROW;
    req.single  = 1'b1;
    req.mod_idx = lmod;
    req.row_idx = 3'(row - 4'd1);
    req.col_idx = col_m1[2:0];
    req.bits    = pixel_bits;
    case (operation)
      lmss_pkg::OP_SET_ROW: begin
        req.ok = row_ok && mod_ok;
      end
      lmss_pkg::OP_SET_COL: begin
        req.ok      = lcol_ok && mod_ok;
        req.kind    = lmss_pkg::KIND_BIT;
        req.single  = 1'b0;
        req.row_idx = 3'd0;
      end
      lmss_pkg::OP_SET_LED: begin
        req.ok   = lcol_ok && row_ok && mod_ok;
        req.kind = lmss_pkg::KIND_BIT;
        req.bits = {8{led_on}};
      end
      lmss_pkg::OP_GLB_COL: begin
        req.ok      = gcol_ok;
        req.kind    = lmss_pkg::KIND_BIT;
        req.single  = 1'b0;
        req.mod_idx = gmod;
        req.row_idx = 3'd0;
      end
      lmss_pkg::OP_GLB_LED: begin
        req.ok      = gcol_ok && row_ok;
        req.kind    = lmss_pkg::KIND_BIT;
        req.mod_idx = gmod;
        req.bits    = {8{led_on}};
      end
      lmss_pkg::OP_REFRESH: begin
        req.ok      = 1'b1;
        req.kind    = lmss_pkg::KIND_REF;
        req.single  = 1'b0;
        req.mod_idx = '0;
        req.row_idx = 3'd0;
      end
      default: begin
        req.ok = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/lmss_seq.sv -----
// Row sequencer: read-modify-write of stored rows and the command output register.
module lmss_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lmss_pkg::req_t                req,
  output logic                          ram_we,
  output logic [lmss_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [7:0]                    ram_wdata,
  output logic                          ram_re,
  output logic [lmss_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [7:0]                    ram_rdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_module,
  output logic [3:0]                    out_address,
  output logic [7:0]                    out_data,
  output logic                          out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MOD
  } state_t;

  state_t                        state;
  lmss_pkg::kind_t               kind;
  logic                          single;
  logic [lmss_pkg::MIDX_W-1:0]   mod_idx;
  logic [2:0]                    row_idx;
  logic [2:0]                    col_idx;
  logic [7:0]                    bits;
  logic [lmss_pkg::DEPTH-1:0]    written;
  logic                          rd_written;
  logic [lmss_pkg::ADDR_W-1:0]   addr;
  logic [7:0]                    cur;
  logic [7:0]                    row_next;
  logic [7:0]                    mask;
  logic                          done;
  logic                          out_free;

  assign in_ready = (state == ST_IDLE);
  assign addr     = {mod_idx, row_idx};
  assign out_free = !out_valid || out_ready;

  // Rows never written read as dark.
  assign cur  = rd_written ? ram_rdata : 8'd0;
  assign mask = 8'd1 << col_idx;

  // New row contents and end-of-request detection.
  always_comb begin
    case (kind)
      lmss_pkg::KIND_ROW: row_next = bits;
      lmss_pkg::KIND_BIT: row_next = bits[row_idx] ? (cur | mask) : (cur & ~mask);
      default:            row_next = cur;
    endcase
    done = single || ((row_idx == 3'd7) &&
           ((kind != lmss_pkg::KIND_REF) ||
            (mod_idx == lmss_pkg::MIDX_W'(lmss_pkg::MODULES - 1))));
  end

  // Memory access: read in the read state, write back in the modify state unless refreshing.
  assign ram_re    = (state == ST_READ);
  assign ram_raddr = addr;
  assign ram_we    = (state == ST_MOD) && (kind != lmss_pkg::KIND_REF);
  assign ram_waddr = addr;
  assign ram_wdata = row_next;

  // State, request registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      written   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && req.ok) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (out_free) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (kind != lmss_pkg::KIND_REF) begin
            written[addr] <= 1'b1;
          end
          out_valid <= 1'b1;
          state     <= done ? ST_IDLE : ST_READ;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end

    // Payload registers.
    if (state == ST_IDLE && in_valid) begin
      kind    <= req.kind;
      single  <= req.single;
      mod_idx <= req.mod_idx;
      row_idx <= req.row_idx;
      col_idx <= req.col_idx;
      bits    <= req.bits;
    end
    if (state == ST_READ) begin
      rd_written <= written[addr];
    end
    if (state == ST_MOD) begin
      out_module  <= 3'(mod_idx) + 3'd1;
      out_address <= {1'b0, row_idx} + 4'd1;
      out_data    <= row_next;
      out_last    <= done;
      row_idx     <= row_idx + 3'd1;
      if (row_idx == 3'd7) begin
        mod_idx <= mod_idx + lmss_pkg::MIDX_W'(1);
      end
    end
  end

  // A valid request always starts a row visit.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && req.ok) |=> (state == ST_READ))
    else $error("accepted request did not start a row visit");

  // Every modify step delivers a command into the output register.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |=> out_valid)
    else $error("modify step produced no command");

  // The modify step is entered only with a free output register.
  a_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |-> $past(out_free))
    else $error("modify step would overwrite a pending command");

  // The last command of a request ends the request.
  a_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD && done) |=> (state == ST_IDLE && out_last))
    else $error("request did not end with its last command");

  // A refresh never changes the store.
  a_refresh: assert property (@(posedge clk) disable iff (rst)
    (kind == lmss_pkg::KIND_REF) |-> !ram_we)
    else $error("refresh wrote the row store");

endmodule

// ----- src/led_matrix_shadow_store_unit.sv -----
// Top level of the LED matrix shadow store: stream ports, decoder, sequencer and row memory.
// Keeps one byte per row for each module of a 4-module chain of 8x8 LED drivers and
// answers each request with one row-register command per row it touches, the final
// command carrying tlast. Requests are taken one at a time. A request is accepted in an
// idle cycle, and after that every command takes a read of the single row memory, then
// the modify and write back. After the request transfer the sequencer passes through its
// read and modify states, and the first command is then registered for output. The next
// request is accepted once the last command of the current one is registered. A read
// waits while a command waits in the output register for tready. A request with a row,
// column or module out of range, or an unused operation code, is consumed without
// output. The store reads as all dark right after reset: per-row written flags stand in
// for a clearing pass.
module led_matrix_shadow_store_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[2:0], row[6:3], column[12:7], module_req[15:13], pixel_bits[23:16],
  // led_on[24], zero[31:25]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // target_module[2:0], register_address[6:3], register_data[14:7], zero[15]
  output logic [15:0] m_tdata,
  output logic        m_tlast
);

  lmss_pkg::req_t              req;
  logic                        ram_we;
  logic [lmss_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                  ram_wdata;
  logic                        ram_re;
  logic [lmss_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                  ram_rdata;
  logic [2:0]                  out_module;
  logic [3:0]                  out_address;
  logic [7:0]                  out_data;

  // Request decode straight from the input transfer.
  lmss_decode u_decode (
    .operation  (s_tdata[2:0]),
    .row        (s_tdata[6:3]),
    .column     (s_tdata[12:7]),
    .module_req (s_tdata[15:13]),
    .pixel_bits (s_tdata[23:16]),
    .led_on     (s_tdata[24]),
    .req        (req)
  );

  // Row visits and command output.
  lmss_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .req         (req),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_module  (out_module),
    .out_address (out_address),
    .out_data    (out_data),
    .out_last    (m_tlast)
  );

  // Row store.
  lmss_ram #(
    .WIDTH (8),
    .DEPTH (lmss_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output packing.
  assign m_tdata = {1'b0, out_data, out_address, out_module};

endmodule
